// ===== rtl/bitvector_similarity_popcount_unit_macros.svh =====
// assertion macros for the bit vector similarity unit
`ifndef BITVECTOR_SIMILARITY_POPCOUNT_UNIT_MACROS_SVH
`define BITVECTOR_SIMILARITY_POPCOUNT_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define BSP_ASSERT_IMP(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define BSP_ASSERT_NXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define BSP_ASSERT_IMP(name, clk, rst_n, ante, cons)
`define BSP_ASSERT_NXT(name, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/bsp_pkg.sv =====
// types and constants shared by the similarity unit
package bsp_pkg;

  localparam int CNT_BITS = 37;
  localparam int STEP_W = 6;
  localparam int IN_BITS = 64;
  localparam int CFG_IDX_W = 1;
  localparam logic [CNT_BITS-1:0] CNT_MAX = {CNT_BITS{1'b1}};

  localparam logic [CFG_IDX_W-1:0] REG_MODE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FILTER = 1'd1;

  typedef struct packed {
    logic [IN_BITS-1:0] word_a;
    logic [IN_BITS-1:0] word_b;
    logic               last;
  } in_word_t;

  typedef struct packed {
    logic [CNT_BITS-1:0] score;
    logic [CNT_BITS-1:0] differ_count;
    logic [CNT_BITS-1:0] union_count;
    logic                empty_union;
  } out_word_t;

  typedef struct packed {
    logic pc_load;
    logic div_start;
    logic div_step;
    logic emit;
  } bsp_cmd_t;

  typedef struct packed {
    logic div_needed;
  } bsp_stat_t;

endpackage

// ===== rtl/bsp_datapath.sv =====
// popcount, running totals, serial scaled divider and result register
`include "bitvector_similarity_popcount_unit_macros.svh"
module bsp_datapath #(
  parameter int WORD_BITS = 64
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  bsp_pkg::bsp_cmd_t                 cmd,
  output bsp_pkg::bsp_stat_t                stat,
  input  bsp_pkg::in_word_t                 in_data,
  input  logic                              cfg_we,
  input  logic [bsp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bsp_pkg::CNT_BITS-1:0]      cfg_data,
  output logic                              out_strobe,
  output bsp_pkg::out_word_t                out_result
);
  import bsp_pkg::*;

  localparam int PC_W = $clog2(WORD_BITS + 1);

  logic [WORD_BITS-1:0] a_m, b_m;
  logic [PC_W-1:0]      pc_diff_r, pc_union_r;
  logic                 pc_valid_r;
  logic [CNT_BITS-1:0]  differ_total_r, union_total_r;
  logic [CNT_BITS:0]    diff_sum, union_sum;
  logic                 mode_r;
  logic [CNT_BITS-1:0]  filter_r;

  logic [CNT_BITS-1:0]  rem_r, quo_r, scale_r, num_r, den_r;
  logic [CNT_BITS:0]    den2_r;
  logic [CNT_BITS+1:0]  trial, sub1, sub2;
  logic [CNT_BITS-1:0]  num_sel, rem_nxt;
  logic [1:0]           qbit;
  logic [CNT_BITS:0]    quo_shift;

  logic [CNT_BITS-1:0]  shared, direct_score, score_sel;
  logic                 union_zero;
  logic                 out_strobe_r;
  out_word_t            out_result_r;

  assign a_m = in_data.word_a[WORD_BITS-1:0];
  assign b_m = in_data.word_b[WORD_BITS-1:0];

  // popcount stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_valid_r <= 1'b0;
    end else begin
      pc_valid_r <= cmd.pc_load;
    end
    if (cmd.pc_load) begin
      pc_diff_r  <= PC_W'($countones(a_m ^ b_m));
      pc_union_r <= PC_W'($countones(a_m | b_m));
    end
  end

  assign diff_sum  = {1'b0, differ_total_r} + (CNT_BITS+1)'(pc_diff_r);
  assign union_sum = {1'b0, union_total_r} + (CNT_BITS+1)'(pc_union_r);

  // saturating totals
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      differ_total_r <= '0;
      union_total_r  <= '0;
    end else if (cmd.emit) begin
      differ_total_r <= '0;
      union_total_r  <= '0;
    end else if (pc_valid_r) begin
      differ_total_r <= diff_sum[CNT_BITS] ? CNT_MAX : diff_sum[CNT_BITS-1:0];
      union_total_r  <= union_sum[CNT_BITS] ? CNT_MAX : union_sum[CNT_BITS-1:0];
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= 1'b0;
      filter_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MODE:   mode_r <= cfg_data[0];
        REG_FILTER: filter_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign union_zero   = (union_total_r == '0);
  assign shared       = (union_total_r >= differ_total_r) ?
                        (union_total_r - differ_total_r) : '0;
  assign direct_score = (filter_r >= differ_total_r) ? (filter_r - differ_total_r) : '0;
  assign stat.div_needed = mode_r && !union_zero;

  // one scale bit per step, remainder kept below den
  assign num_sel = scale_r[CNT_BITS-1] ? num_r : '0;
  assign trial   = {1'b0, rem_r, 1'b0} + {2'b00, num_sel};
  assign sub1    = trial - {2'b00, den_r};
  assign sub2    = trial - {1'b0, den2_r};

  always_comb begin
    if (trial >= {1'b0, den2_r}) begin
      rem_nxt = sub2[CNT_BITS-1:0];
      qbit    = 2'd2;
    end else if (trial >= {2'b00, den_r}) begin
      rem_nxt = sub1[CNT_BITS-1:0];
      qbit    = 2'd1;
    end else begin
      rem_nxt = trial[CNT_BITS-1:0];
      qbit    = 2'd0;
    end
  end

  assign quo_shift = {quo_r, 1'b0} + (CNT_BITS+1)'(qbit);

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      rem_r   <= '0;
      quo_r   <= '0;
      scale_r <= filter_r;
      num_r   <= shared;
      den_r   <= union_total_r;
      den2_r  <= {union_total_r, 1'b0};
    end else if (cmd.div_step) begin
      rem_r   <= rem_nxt;
      quo_r   <= quo_shift[CNT_BITS-1:0];
      scale_r <= {scale_r[CNT_BITS-2:0], 1'b0};
    end
  end

  always_comb begin
    if (!mode_r) begin
      score_sel = direct_score;
    end else if (union_zero) begin
      score_sel = '0;
    end else begin
      score_sel = quo_r;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= cmd.emit;
    end
    if (cmd.emit) begin
      out_result_r.score        <= score_sel;
      out_result_r.differ_count <= differ_total_r;
      out_result_r.union_count  <= union_total_r;
      out_result_r.empty_union  <= mode_r && union_zero;
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_result = out_result_r;

  `BSP_ASSERT_IMP(a_emit_no_pending, clk, rst_n, cmd.emit, !pc_valid_r)
  `BSP_ASSERT_IMP(a_div_nonzero_den, clk, rst_n, cmd.div_start, !union_zero)
  `BSP_ASSERT_IMP(a_rem_below_den, clk, rst_n, cmd.div_step, rem_r < den_r)
  `BSP_ASSERT_IMP(a_totals_cleared, clk, rst_n, out_strobe_r,
                  differ_total_r == '0 && union_total_r == '0)

endmodule

// ===== rtl/bsp_ctrl.sv =====
// controller sequencing accumulation, scaled division and result
module bsp_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic                in_last,
  input  bsp_pkg::bsp_stat_t  stat,
  output bsp_pkg::bsp_cmd_t   cmd,
  output logic                busy
);
  import bsp_pkg::*;

  typedef enum logic [2:0] {
    S_ACC,
    S_WAIT,
    S_FINAL,
    S_DIV,
    S_EMIT
  } state_t;

  state_t             state_r, state_nxt;
  logic [STEP_W-1:0]  cnt_r, cnt_nxt;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    cmd           = '0;
    unique case (state_r)
      S_ACC: begin
        cmd.pc_load = start;
        if (start && in_last) begin
          state_nxt = S_WAIT;
        end
      end
      S_WAIT: begin
        state_nxt = S_FINAL;
      end
      S_FINAL: begin
        if (stat.div_needed) begin
          cmd.div_start = 1'b1;
          cnt_nxt       = STEP_W'(CNT_BITS - 1);
          state_nxt     = S_DIV;
        end else begin
          cmd.emit  = 1'b1;
          state_nxt = S_ACC;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        cmd.emit  = 1'b1;
        state_nxt = S_ACC;
      end
      default: begin
        state_nxt = S_ACC;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_ACC;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  assign busy = (state_r != S_ACC);

endmodule

// ===== rtl/bitvector_similarity_popcount_unit.sv =====
// top level of the bit vector xor/or popcount similarity unit
// usage:
//   configure similarity_mode (index 0) and filter_bits (index 1) on the cfg_ port
//   while idle; writes take effect at the edge where cfg_we is high
//   stream word pairs on in_data, one per cycle, with start high; a word is taken
//   at an edge where start is high and busy is low
//   words without last are taken back to back, busy stays low
//   after a word with last, busy rises until the result has been loaded
//   the result shows on out_result for one cycle with out_strobe high
//   after the edge taking the last word, the controller passes S_WAIT and S_FINAL;
//   in mode 0 or with an empty union S_FINAL loads the result, in mode 1 it starts
//   the 37-step one-bit-per-cycle divider and S_EMIT then loads the result
//   the next vector pair may start in the cycle after busy falls
//   the receiver cannot stall; the result is valid for exactly one cycle
//   reset clears the totals, the configuration and the controller
module bitvector_similarity_popcount_unit #(
  parameter int WORD_BITS = 64
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  bsp_pkg::in_word_t              in_data,
  input  logic                           cfg_we,
  input  logic [bsp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bsp_pkg::CNT_BITS-1:0]   cfg_data,
  output logic                           out_strobe,
  output bsp_pkg::out_word_t             out_result
);
  import bsp_pkg::*;

  bsp_cmd_t  cmd;
  bsp_stat_t stat;

  bsp_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_last (in_data.last),
    .stat    (stat),
    .cmd     (cmd),
    .busy    (busy)
  );

  bsp_datapath #(
    .WORD_BITS (WORD_BITS)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_data    (in_data),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_strobe (out_strobe),
    .out_result (out_result)
  );

endmodule
